### design/sorted_priority_queue_macros.svh
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Shared concurrent assertion forms used by the queue's top level.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SPQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Field widths, operation and status codes, and controller/datapath bundles.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int RANK_W        = 16;
   localparam int FIELD_DW      = 32;
   localparam int COUNT_FIELD_W = 5;
   localparam int KIND_W        = 2;
   localparam int STATUS_W      = 2;

   // operation kinds
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd3;

   // result status
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

   // read address select
   localparam logic [1:0] RD_ZERO        = 2'd0;
   localparam logic [1:0] RD_LAST        = 2'd1;
   localparam logic [1:0] RD_IDX_NEXT    = 2'd2;
   localparam logic [1:0] RD_IDX_NEXT_M1 = 2'd3;

   // index register update
   localparam logic [2:0] IDX_HOLD     = 3'd0;
   localparam logic [2:0] IDX_LOAD_CNT = 3'd1;
   localparam logic [2:0] IDX_LOAD_ONE = 3'd2;
   localparam logic [2:0] IDX_DEC      = 3'd3;
   localparam logic [2:0] IDX_INC      = 3'd4;

   // entry count update
   localparam logic [1:0] CNT_HOLD  = 2'd0;
   localparam logic [1:0] CNT_INC   = 2'd1;
   localparam logic [1:0] CNT_DEC   = 2'd2;
   localparam logic [1:0] CNT_CLEAR = 2'd3;

   typedef struct packed {
      logic                load_req;
      logic                rd_en;
      logic [1:0]          rd_sel;
      logic                wr_en;
      logic                wr_new;    // write the pending entry, else the read beat
      logic                wr_lower;  // write at idx-1, else at idx
      logic [2:0]          idx_op;
      logic [1:0]          cnt_op;
      logic                cap_removed;
      logic                set_status;
      logic [STATUS_W-1:0] status_code;
      logic                clr_ends;
      logic                cap_front;
      logic                cap_tail;
      logic                emit;
   } spq_cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              empty;
      logic              full;
      logic              rank_lt;      // read entry ranks below the pending one
      logic              idx_one;
      logic              idx_lt_cnt;
      logic              next_lt_cnt;  // idx+1 below count
   } spq_stat_type;

endpackage

### design/spq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module spq_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/spq_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted priority queue controller
// Sequences insert shifts, remove shifts and the front/tail report.
// ----------------------------------------------------------------------------
module spq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  spq_pkg::spq_stat_type st,
   output spq_pkg::spq_cmd_type  cmd
);

   import spq_pkg::*;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_DISPATCH  = 4'd1;
   localparam logic [3:0] S_INS_CMP   = 4'd2;
   localparam logic [3:0] S_INS_PUT   = 4'd3;
   localparam logic [3:0] S_REM_HEAD  = 4'd4;
   localparam logic [3:0] S_REM_MOVE  = 4'd5;
   localparam logic [3:0] S_REPORT    = 4'd6;
   localparam logic [3:0] S_RPT_FRONT = 4'd7;
   localparam logic [3:0] S_RPT_TAIL  = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               cmd.idx_op   = IDX_LOAD_CNT;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_REPORT;
            case (st.kind)
               KIND_INSERT: begin
                  if (st.full) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STAT_FULL;
                  end else if (st.empty) begin
                     cmd.wr_en  = 1'b1;
                     cmd.wr_new = 1'b1;
                     cmd.cnt_op = CNT_INC;
                  end else begin
                     // fetch the tail, idx holds the count
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_IDX_NEXT_M1;
                     state_in   = S_INS_CMP;
                  end
               end
               KIND_REMOVE: begin
                  if (st.empty) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STAT_EMPTY;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_ZERO;
                     cmd.idx_op = IDX_LOAD_ONE;
                     state_in   = S_REM_HEAD;
                  end
               end
               KIND_CLEAR: begin
                  if (st.empty) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STAT_EMPTY;
                  end else begin
                     cmd.cnt_op = CNT_CLEAR;
                  end
               end
               default: begin
                  // query: report only
               end
            endcase
         end
         S_INS_CMP: begin
            cmd.wr_en = 1'b1;
            if (st.rank_lt) begin
               // move the lower entry down one slot, keep scanning up
               cmd.idx_op = IDX_DEC;
               if (st.idx_one) begin
                  state_in = S_INS_PUT;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_IDX_NEXT_M1;
               end
            end else begin
               cmd.wr_new = 1'b1;
               cmd.cnt_op = CNT_INC;
               state_in   = S_REPORT;
            end
         end
         S_INS_PUT: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_new = 1'b1;
            cmd.cnt_op = CNT_INC;
            state_in   = S_REPORT;
         end
         S_REM_HEAD: begin
            cmd.cap_removed = 1'b1;
            if (st.idx_lt_cnt) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_IDX_NEXT;
               state_in   = S_REM_MOVE;
            end else begin
               cmd.cnt_op = CNT_DEC;
               state_in   = S_REPORT;
            end
         end
         S_REM_MOVE: begin
            cmd.wr_en    = 1'b1;
            cmd.wr_lower = 1'b1;
            cmd.idx_op   = IDX_INC;
            if (st.next_lt_cnt) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_IDX_NEXT;
            end else begin
               cmd.cnt_op = CNT_DEC;
               state_in   = S_REPORT;
            end
         end
         S_REPORT: begin
            if (st.empty) begin
               cmd.clr_ends = 1'b1;
               cmd.emit     = 1'b1;
               state_in     = S_IDLE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_ZERO;
               state_in   = S_RPT_FRONT;
            end
         end
         S_RPT_FRONT: begin
            cmd.cap_front = 1'b1;
            cmd.rd_en     = 1'b1;
            cmd.rd_sel    = RD_LAST;
            state_in      = S_RPT_TAIL;
         end
         S_RPT_TAIL: begin
            cmd.cap_tail = 1'b1;
            cmd.emit     = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

### design/spq_datapath.sv
// ----------------------------------------------------------------------------
// Sorted priority queue datapath
// Entry store, index and count registers, and the result registers.
// ----------------------------------------------------------------------------
module spq_datapath #(
   parameter int CAPACITY   = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [spq_pkg::KIND_W-1:0]         req_kind,
   input  logic [spq_pkg::RANK_W-1:0]         req_entry_rank,
   input  logic [spq_pkg::FIELD_DW-1:0]       req_entry_data,
   input  spq_pkg::spq_cmd_type               cmd,
   output spq_pkg::spq_stat_type              st,
   output logic                               rsp_valid,
   output logic [spq_pkg::STATUS_W-1:0]       rsp_status,
   output logic [spq_pkg::RANK_W-1:0]         rsp_removed_rank,
   output logic [spq_pkg::FIELD_DW-1:0]       rsp_removed_data,
   output logic [spq_pkg::RANK_W-1:0]         rsp_front_rank,
   output logic [spq_pkg::FIELD_DW-1:0]       rsp_front_data,
   output logic [spq_pkg::RANK_W-1:0]         rsp_tail_rank,
   output logic [spq_pkg::FIELD_DW-1:0]       rsp_tail_data,
   output logic [spq_pkg::COUNT_FIELD_W-1:0]  rsp_entry_count
);

   import spq_pkg::*;

   localparam int SDW = (DATA_WIDTH < FIELD_DW) ? DATA_WIDTH : FIELD_DW;
   localparam int EW  = RANK_W + SDW;
   localparam int IW  = $clog2(CAPACITY + 1);
   localparam int AW  = $clog2(CAPACITY);
   localparam int CXW = (IW > COUNT_FIELD_W) ? IW : COUNT_FIELD_W;

   logic [KIND_W-1:0]   kind_ff;
   logic [RANK_W-1:0]   rank_ff;
   logic [SDW-1:0]      data_ff;
   logic [IW-1:0]       idx_ff, idx_in;
   logic [IW-1:0]       count_ff, count_in;
   logic [IW-1:0]       rd_addr_full, wr_addr_full;
   logic [EW-1:0]       wr_data, rd_data;
   logic [RANK_W-1:0]   rd_rank;
   logic [SDW-1:0]      rd_dat;
   logic [CXW-1:0]      count_ext;

   logic                 valid_ff;
   logic [STATUS_W-1:0]  status_ff;
   logic [RANK_W-1:0]    rem_rank_ff, front_rank_ff, tail_rank_ff;
   logic [SDW-1:0]       rem_data_ff, front_data_ff, tail_data_ff;
   logic [COUNT_FIELD_W-1:0] out_count_ff;

   assign rd_rank = rd_data[EW-1 -: RANK_W];
   assign rd_dat  = rd_data[SDW-1:0];

   always_comb begin
      case (cmd.idx_op)
         IDX_LOAD_CNT: idx_in = count_ff;
         IDX_LOAD_ONE: idx_in = IW'(1);
         IDX_DEC:      idx_in = idx_ff - IW'(1);
         IDX_INC:      idx_in = idx_ff + IW'(1);
         default:      idx_in = idx_ff;
      endcase
   end

   always_comb begin
      case (cmd.cnt_op)
         CNT_INC:   count_in = count_ff + IW'(1);
         CNT_DEC:   count_in = count_ff - IW'(1);
         CNT_CLEAR: count_in = '0;
         default:   count_in = count_ff;
      endcase
   end

   always_comb begin
      case (cmd.rd_sel)
         RD_ZERO:        rd_addr_full = '0;
         RD_LAST:        rd_addr_full = count_ff - IW'(1);
         RD_IDX_NEXT:    rd_addr_full = idx_in;
         RD_IDX_NEXT_M1: rd_addr_full = idx_in - IW'(1);
         default:        rd_addr_full = '0;
      endcase
   end

   assign wr_addr_full = cmd.wr_lower ? (idx_ff - IW'(1)) : idx_ff;
   assign wr_data      = cmd.wr_new ? {rank_ff, data_ff} : rd_data;

   spq_ram #(
      .WIDTH (EW),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr_full[AW-1:0]),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr_full[AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      st.kind        = kind_ff;
      st.empty       = (count_ff == '0);
      st.full        = (count_ff == IW'(CAPACITY));
      st.rank_lt     = (rd_rank < rank_ff);
      st.idx_one     = (idx_ff == IW'(1));
      st.idx_lt_cnt  = (idx_ff < count_ff);
      st.next_lt_cnt = (({1'b0, idx_ff} + (IW + 1)'(1)) < {1'b0, count_ff});
   end

   assign count_ext = CXW'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.load_req) begin
         kind_ff     <= req_kind;
         rank_ff     <= req_entry_rank;
         data_ff     <= req_entry_data[SDW-1:0];
         status_ff   <= STAT_OK;
         rem_rank_ff <= '0;
         rem_data_ff <= '0;
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status_code;
      end
      if (cmd.cap_removed) begin
         rem_rank_ff <= rd_rank;
         rem_data_ff <= rd_dat;
      end
      if (cmd.clr_ends) begin
         front_rank_ff <= '0;
         front_data_ff <= '0;
         tail_rank_ff  <= '0;
         tail_data_ff  <= '0;
      end
      if (cmd.cap_front) begin
         front_rank_ff <= rd_rank;
         front_data_ff <= rd_dat;
      end
      if (cmd.cap_tail) begin
         tail_rank_ff <= rd_rank;
         tail_data_ff <= rd_dat;
      end
      if (cmd.emit) begin
         out_count_ff <= count_ext[COUNT_FIELD_W-1:0];
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_removed_rank = rem_rank_ff;
   assign rsp_removed_data = FIELD_DW'(rem_data_ff);
   assign rsp_front_rank   = front_rank_ff;
   assign rsp_front_data   = FIELD_DW'(front_data_ff);
   assign rsp_tail_rank    = tail_rank_ff;
   assign rsp_tail_data    = FIELD_DW'(tail_data_ff);
   assign rsp_entry_count  = out_count_ff;

endmodule

### design/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded queue of rank/payload entries, highest rank at the front.
// ----------------------------------------------------------------------------
// Usage: pulse start with req_kind (insert, remove front, clear, query) and,
// for insert, req_entry_rank / req_entry_data. The beat is taken on an edge
// where start is high and busy is low. Every command gives exactly one result
// beat: rsp_valid is high for one cycle and the rsp_ fields are valid only
// then. The receiver cannot stall, so capture the beat when it comes. Equal
// ranks leave in arrival order. Duration is set by the entry store, which
// moves one entry per cycle: query and clear shift nothing; an insert shifts
// each entry of lower rank down one slot (at most CAPACITY-1 of them) and
// then writes the new one, and a remove shifts every remaining entry up one
// slot. A rejected insert, an insert into an empty queue and a remove on an
// empty queue shift nothing. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue #(
   parameter int CAPACITY   = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [spq_pkg::KIND_W-1:0]         req_kind,
   input  logic [spq_pkg::RANK_W-1:0]         req_entry_rank,
   input  logic [spq_pkg::FIELD_DW-1:0]       req_entry_data,
   output logic                               rsp_valid,
   output logic [spq_pkg::STATUS_W-1:0]       rsp_status,
   output logic [spq_pkg::RANK_W-1:0]         rsp_removed_rank,
   output logic [spq_pkg::FIELD_DW-1:0]       rsp_removed_data,
   output logic [spq_pkg::RANK_W-1:0]         rsp_front_rank,
   output logic [spq_pkg::FIELD_DW-1:0]       rsp_front_data,
   output logic [spq_pkg::RANK_W-1:0]         rsp_tail_rank,
   output logic [spq_pkg::FIELD_DW-1:0]       rsp_tail_data,
   output logic [spq_pkg::COUNT_FIELD_W-1:0]  rsp_entry_count
);

   import spq_pkg::*;

   // command / status bundles between sequencer and datapath
   spq_cmd_type  cmd;
   spq_stat_type st;

   // sequencer: one command at a time, busy from accept until the strobe
   spq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .st    (st),
      .cmd   (cmd)
   );

   // store, index/count registers and result registers
   spq_datapath #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_kind         (req_kind),
      .req_entry_rank   (req_entry_rank),
      .req_entry_data   (req_entry_data),
      .cmd              (cmd),
      .st               (st),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_removed_rank (rsp_removed_rank),
      .rsp_removed_data (rsp_removed_data),
      .rsp_front_rank   (rsp_front_rank),
      .rsp_front_data   (rsp_front_data),
      .rsp_tail_rank    (rsp_tail_rank),
      .rsp_tail_data    (rsp_tail_data),
      .rsp_entry_count  (rsp_entry_count)
   );

   // an accepted command keeps the block busy next cycle
   `SPQ_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "busy not raised after accept")
   // results never come back to back
   `SPQ_ASSERT_NEXT(a_single_beat, clock, reset, rsp_valid, !rsp_valid, "result strobe held over")
   // the store is only written while a command is in flight
   `SPQ_ASSERT_SAME(a_idle_no_write, clock, reset, !busy, !cmd.wr_en, "store written while idle")
   // an empty report shows an empty queue
   `SPQ_ASSERT_SAME(a_empty_report, clock, reset, rsp_valid && rsp_status == STAT_EMPTY, rsp_entry_count == '0 && rsp_front_rank == '0 && rsp_tail_rank == '0, "empty status with entries")

endmodule

### tb/sorted_priority_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// A clocked driver takes command beats from a backlog that an initial block
// fills: a directed opening and then random bursts that lean toward filling
// or draining the queue. Each accepted beat runs through a behavioral copy of
// the queue. The monitor compares every result strobe with the oldest
// predicted outcome.
// ----------------------------------------------------------------------------
module sorted_priority_queue_tb;
   import spq_pkg::*;

   localparam int CAPACITY    = 16;
   localparam int CYCLE_LIMIT = 200000;   // ample for about 430 beats with their idle gaps
   localparam int RANDOM_BEATS = 400;

   // one command beat plus the idle time the driver inserts after it
   typedef struct {
      logic [KIND_W-1:0]   kind;
      logic [RANK_W-1:0]   rank;
      logic [FIELD_DW-1:0] data;
      int                  gap;
   } queue_cmd_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic [RANK_W-1:0]        removed_rank;
      logic [FIELD_DW-1:0]      removed_data;
      logic [RANK_W-1:0]        front_rank;
      logic [FIELD_DW-1:0]      front_data;
      logic [RANK_W-1:0]        tail_rank;
      logic [FIELD_DW-1:0]      tail_data;
      logic [COUNT_FIELD_W-1:0] entry_count;
   } queue_outcome_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [KIND_W-1:0]         req_kind = KIND_QUERY;
   logic [RANK_W-1:0]         req_entry_rank = '0;
   logic [FIELD_DW-1:0]       req_entry_data = '0;
   logic                      rsp_valid;
   logic [STATUS_W-1:0]       rsp_status;
   logic [RANK_W-1:0]         rsp_removed_rank;
   logic [FIELD_DW-1:0]       rsp_removed_data;
   logic [RANK_W-1:0]         rsp_front_rank;
   logic [FIELD_DW-1:0]       rsp_front_data;
   logic [RANK_W-1:0]         rsp_tail_rank;
   logic [FIELD_DW-1:0]       rsp_tail_data;
   logic [COUNT_FIELD_W-1:0]  rsp_entry_count;

   queue_cmd_type     cmd_backlog[$];
   queue_outcome_type outcome_q[$];

   // shadow of the queue contents, front at index 0
   logic [RANK_W-1:0]   rank_shadow[CAPACITY];
   logic [FIELD_DW-1:0] payload_shadow[CAPACITY];
   int                  held_shadow = 0;

   int idle_left  = 0;
   int mismatches = 0;
   int cycles     = 0;

   sorted_priority_queue #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (FIELD_DW)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_entry_rank   (req_entry_rank),
      .req_entry_data   (req_entry_data),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_removed_rank (rsp_removed_rank),
      .rsp_removed_data (rsp_removed_data),
      .rsp_front_rank   (rsp_front_rank),
      .rsp_front_data   (rsp_front_data),
      .rsp_tail_rank    (rsp_tail_rank),
      .rsp_tail_data    (rsp_tail_data),
      .rsp_entry_count  (rsp_entry_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Apply one accepted command to the shadow queue and queue up its outcome.
   // A new entry lands behind every entry of greater or equal rank, so ties
   // leave in arrival order and a tie with the tail becomes the new tail.
   task automatic predict_outcome(input logic [KIND_W-1:0] kind,
                                  input logic [RANK_W-1:0] rank,
                                  input logic [FIELD_DW-1:0] data);
      queue_outcome_type res;
      int                pos;
      res = '0;
      res.status = STAT_OK;
      case (kind)
         KIND_INSERT: begin
            if (held_shadow >= CAPACITY) begin
               res.status = STAT_FULL;
            end else begin
               pos = 0;
               while (pos < held_shadow && rank_shadow[pos] >= rank) pos++;
               for (int i = held_shadow; i > pos; i--) begin
                  rank_shadow[i]    = rank_shadow[i-1];
                  payload_shadow[i] = payload_shadow[i-1];
               end
               rank_shadow[pos]    = rank;
               payload_shadow[pos] = data;
               held_shadow++;
            end
         end
         KIND_REMOVE: begin
            if (held_shadow == 0) begin
               res.status = STAT_EMPTY;
            end else begin
               res.removed_rank = rank_shadow[0];
               res.removed_data = payload_shadow[0];
               for (int i = 1; i < held_shadow; i++) begin
                  rank_shadow[i-1]    = rank_shadow[i];
                  payload_shadow[i-1] = payload_shadow[i];
               end
               held_shadow--;
            end
         end
         KIND_CLEAR: begin
            if (held_shadow == 0) res.status = STAT_EMPTY;
            else held_shadow = 0;
         end
         default: ;   // query leaves the contents alone
      endcase
      // front and tail read as zero on an empty queue
      if (held_shadow > 0) begin
         res.front_rank = rank_shadow[0];
         res.front_data = payload_shadow[0];
         res.tail_rank  = rank_shadow[held_shadow-1];
         res.tail_data  = payload_shadow[held_shadow-1];
      end
      res.entry_count = held_shadow[COUNT_FIELD_W-1:0];
      outcome_q.push_back(res);
   endtask

   // mostly back to back or short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(13, 40);
   endfunction

   function automatic logic [RANK_W-1:0] pick_rank();
      // narrow bands make ties common; the wide draw covers every bit
      case ($urandom_range(0, 3))
         0: return RANK_W'($urandom_range(0, 3));
         1: return 16'hFFFF - RANK_W'($urandom_range(0, 3));
         2: return RANK_W'($urandom_range(100, 107));
         default: return RANK_W'($urandom);
      endcase
   endfunction

   task automatic push_cmd(input logic [KIND_W-1:0] kind,
                           input logic [RANK_W-1:0] rank,
                           input logic [FIELD_DW-1:0] data,
                           input int gap);
      queue_cmd_type c;
      c.kind = kind;
      c.rank = rank;
      c.data = data;
      c.gap  = gap;
      cmd_backlog.push_back(c);
   endtask

   // Driver: sample the handshake as it stood before the edge, feed the shadow
   // model on acceptance, then present the next beat or idle. start gets a
   // single nonblocking update per edge, so a back-to-back beat simply keeps
   // it high with new fields.
   always @(posedge clock) begin
      queue_cmd_type c;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy)
            predict_outcome(req_kind, req_entry_rank, req_entry_data);
         if (!start || !busy) begin
            if (idle_left > 0) begin
               idle_left <= idle_left - 1;
               start     <= 1'b0;
            end else if (cmd_backlog.size() > 0) begin
               c = cmd_backlog.pop_front();
               req_kind       <= c.kind;
               req_entry_rank <= c.rank;
               req_entry_data <= c.data;
               start          <= 1'b1;
               idle_left      <= c.gap;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: the receiver cannot stall, so every strobe is one result beat.
   always @(posedge clock) begin
      queue_outcome_type got, want;
      if (!reset && rsp_valid) begin
         got = {rsp_status, rsp_removed_rank, rsp_removed_data, rsp_front_rank,
                rsp_front_data, rsp_tail_rank, rsp_tail_data, rsp_entry_count};
         if (outcome_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result beat with nothing outstanding", $realtime);
         end else begin
            want = outcome_q.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: mismatch exp st=%0d rm=%h/%h fr=%h/%h tl=%h/%h n=%0d",
                           $realtime, want.status, want.removed_rank, want.removed_data,
                           want.front_rank, want.front_data, want.tail_rank,
                           want.tail_data, want.entry_count);
                  $display("%0t:          got st=%0d rm=%h/%h fr=%h/%h tl=%h/%h n=%0d",
                           $realtime, got.status, got.removed_rank, got.removed_data,
                           got.front_rank, got.front_data, got.tail_rank,
                           got.tail_data, got.entry_count);
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      int issued;
      int burst;
      int lean;
      int no_idle;
      int r;
      logic [KIND_W-1:0] k;

      // --- directed opening ---
      // operations on an empty queue: query still succeeds, the others report empty
      push_cmd(KIND_QUERY,  '0, '0, pick_gap());
      push_cmd(KIND_REMOVE, '0, '0, pick_gap());
      push_cmd(KIND_CLEAR,  '0, '0, pick_gap());
      // extreme ranks and payloads, then ties with the tail and with the front
      push_cmd(KIND_INSERT, 16'h0000, 32'h0000_0000, pick_gap());
      push_cmd(KIND_INSERT, 16'hFFFF, 32'hFFFF_FFFF, pick_gap());
      push_cmd(KIND_INSERT, 16'h0000, 32'h5A5A_A5A5, pick_gap());
      push_cmd(KIND_INSERT, 16'hFFFF, 32'hA5A5_5A5A, 0);
      push_cmd(KIND_REMOVE, '0, '0, pick_gap());
      push_cmd(KIND_CLEAR,  '0, '0, pick_gap());
      // fill to capacity with ties mixed in, then one insert too many
      for (int i = 0; i < CAPACITY; i++)
         push_cmd(KIND_INSERT, pick_rank(), $urandom, pick_gap());
      push_cmd(KIND_INSERT, 16'h8000, 32'hDEAD_BEEF, pick_gap());

      // --- random bursts ---
      // Each burst leans toward filling, draining or a mix, so full and empty
      // both come up often; some bursts run with no idle cycles at all.
      issued = 0;
      while (issued < RANDOM_BEATS) begin
         burst   = $urandom_range(8, 30);
         lean    = $urandom_range(0, 2);
         no_idle = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < burst; i++) begin
            r = $urandom_range(0, 99);
            if (r < 4)        k = KIND_CLEAR;
            else if (r < 12)  k = KIND_QUERY;
            else if (lean == 0) k = (r < 80) ? KIND_INSERT : KIND_REMOVE;
            else if (lean == 1) k = (r < 30) ? KIND_INSERT : KIND_REMOVE;
            else              k = (r < 56) ? KIND_INSERT : KIND_REMOVE;
            // rank and payload are random on every kind; only insert uses them
            push_cmd(k, pick_rank(), $urandom, no_idle ? 0 : pick_gap());
            issued++;
         end
      end

      // hold reset, then release it
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // drain: everything sent and accepted, every outcome seen
      do @(posedge clock);
      while (cmd_backlog.size() != 0 || start || outcome_q.size() != 0);
      // catch stray beats
      repeat (40) @(posedge clock);

      if (mismatches == 0 && outcome_q.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
